// File: design/vertex_transform_project_assert.svh
// Assertion helpers shared by the checking code of the vertex transform block.
`ifndef VERTEX_TRANSFORM_PROJECT_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_ASSERT_SVH

// Same-cycle implication under active-low reset
`define VTP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under active-low reset
`define VTP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vtp_pkg.sv
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int COORD_W = 32;
  localparam int COLOR_W = 24;

  // Request kind carried in tuser
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_VERTEX = 1'b1
  } vtp_cmd_e;

  // Configuration register indexes
  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_FAR  = 1'b1;

  // Depth result selection
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_FULL = 2'd1,
    SEL_QUOT = 2'd2
  } vtp_dsel_e;

  // Tag riding with the z lane divider
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               wzero;
    logic               neg;
  } vtp_ztag_t;

  // Tag riding with the depth divider
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COLOR_W-1:0] color;
    logic               fault;
    vtp_dsel_e          sel;
  } vtp_side_t;

endpackage

// File: design/vertex_transform_project.sv
`timescale 1ns / 1ps
`include "vertex_transform_project_assert.svh"
// Vertex transform and perspective projection.
// Slave stream: tuser = cmd. A load request writes one coefficient of the
// 4x4 matrix; a vertex request yields one result on the master stream.
// Loads take effect for every vertex accepted after them.
// Config port: cfg_we_i writes near (index 0) or far (index 1) plane.
// A vertex result passes the row lane product and sum registers, the setup
// register, the (32+FRAC_BITS)-stage x/y/z divider, the merge register, the
// offset, range and clamp registers of the depth setup, the 32-stage depth
// divider and the output register.
// Throughput: one request per cycle while s_axis_tready is high.
// Reset loads the identity matrix, near = 1.0, far = 100.0, and empties
// the pipeline. When the receiver stalls, the result waits in the output
// register; the pipeline keeps moving and accepting until a finished
// result reaches its last stage, then tready drops until the output drains.
module vertex_transform_project
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coef_index, coef_value, vert_x, vert_y, vert_z, vert_w, red, green, blue
  input  logic [215:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // screen_x, screen_y, depth_value, packed_color
  output logic [119:0] m_axis_tdata,
  // divide_fault
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int NW = COORD_W + FRAC_BITS;
  localparam int DDW = COORD_W + 1;

  // Input fields
  logic [3:0]                coef_index;
  logic signed [COORD_W-1:0] coef_value;
  logic signed [COORD_W-1:0] vec [4];
  logic [16:0]               red_level, green_level, blue_level;

  assign coef_index  = s_axis_tdata[3:0];
  assign coef_value  = s_axis_tdata[35:4];
  assign vec[0]      = s_axis_tdata[67:36];
  assign vec[1]      = s_axis_tdata[99:68];
  assign vec[2]      = s_axis_tdata[131:100];
  assign vec[3]      = s_axis_tdata[163:132];
  assign red_level   = s_axis_tdata[180:164];
  assign green_level = s_axis_tdata[197:181];
  assign blue_level  = s_axis_tdata[214:198];

  // Flow control
  logic acc, en, ld, v_last, out_v_q;
  assign ld            = !out_v_q || m_axis_tready;
  assign en            = ld || !v_last;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Matrix store
  logic signed [COORD_W-1:0] mat_q [16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= (i % 5 == 0) ? COORD_W'(1) << FRAC_BITS : '0;
      end
    end else if (acc && s_axis_tuser == CMD_LOAD) begin
      mat_q[coef_index] <= coef_value;
    end
  end

  // Plane registers
  logic signed [COORD_W-1:0] near_q, far_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= 32'sd65536;
      far_q  <= 32'sd6553600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEAR: near_q <= cfg_data_i;
        REG_FAR:  far_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Row lanes
  logic signed [COORD_W-1:0] rowc [4][4];
  logic signed [COORD_W-1:0] t    [4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        rowc[r][c] = mat_q[r*4+c];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    vtp_row_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (rowc[r]),
      .vec_i  (vec),
      .sum_o  (t[r])
    );
  end

  // Color channel: floor(255 * min(c, 1.0))
  function automatic logic [7:0] chan(input logic [16:0] c);
    logic [16:0] cc;
    logic [24:0] m;
    cc = (c > 17'd65536) ? 17'd65536 : c;
    m  = {cc, 8'b0} - 25'(cc);
    return m[23:16];
  endfunction

  // Stages 1 and 2 run beside the lanes
  logic [COLOR_W-1:0] col1_q, col2_q;
  logic               v1_q, v2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      col1_q <= {chan(red_level), chan(green_level), chan(blue_level)};
      col2_q <= col1_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc && s_axis_tuser == CMD_VERTEX;
      v2_q <= v1_q;
    end
  end

  // Stage 3: magnitudes for the dividers
  function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] a);
    return a[COORD_W-1] ? COORD_W'(-a) : a;
  endfunction

  logic [NW-1:0]      nx_q, ny_q, nz_q;
  logic [COORD_W-1:0] dw_q;
  logic               negx_q, negy_q;
  vtp_ztag_t          ztag_q;
  logic               v3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q         <= {mag(t[0]), FRAC_BITS'(0)};
      ny_q         <= {mag(t[1]), FRAC_BITS'(0)};
      nz_q         <= {mag(t[2]), FRAC_BITS'(0)};
      dw_q         <= mag(t[3]);
      negx_q       <= t[0][COORD_W-1] ^ t[3][COORD_W-1];
      negy_q       <= t[1][COORD_W-1] ^ t[3][COORD_W-1];
      ztag_q.neg   <= t[2][COORD_W-1] ^ t[3][COORD_W-1];
      ztag_q.wzero <= (t[3] == '0);
      ztag_q.color <= col2_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  // Divider lanes for x, y and z
  logic [NW-1:0] qx, qy, qz;
  logic          negx_o, negy_o, vx, vy, vz;
  vtp_ztag_t     ztag_o;

  vtp_div #(.NW(NW), .DW(COORD_W), .SW(1)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .v_i(v3_q), .rem_i('0), .num_i(nx_q),
    .den_i(dw_q), .side_i(negx_q), .v_o(vx), .quo_o(qx), .side_o(negx_o)
  );
  vtp_div #(.NW(NW), .DW(COORD_W), .SW(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .v_i(v3_q), .rem_i('0), .num_i(ny_q),
    .den_i(dw_q), .side_i(negy_q), .v_o(vy), .quo_o(qy), .side_o(negy_o)
  );
  vtp_div #(.NW(NW), .DW(COORD_W), .SW($bits(vtp_ztag_t))) u_div_z (
    .clk_i, .rst_ni, .en_i(en), .v_i(v3_q), .rem_i('0), .num_i(nz_q),
    .den_i(dw_q), .side_i(ztag_q), .v_o(vz), .quo_o(qz), .side_o(ztag_o)
  );

  // Signed, saturated quotient
  function automatic logic [COORD_W-1:0] div_sat(input logic [NW-1:0] q, input logic neg);
    if (!neg && q > NW'(33'h0_7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (neg && q > NW'(33'h0_8000_0000)) begin
      return 32'h8000_0000;
    end else begin
      return neg ? COORD_W'(-q[COORD_W-1:0]) : q[COORD_W-1:0];
    end
  endfunction

  // Stage 4: merge lanes
  logic [COORD_W-1:0]        sx4_q, sy4_q, sx5_q, sy5_q, sx6_q, sy6_q;
  logic signed [COORD_W-1:0] qz4_q;
  logic [COLOR_W-1:0]        col4_q, col5_q, col6_q;
  logic                      wz4_q, wz5_q, wz6_q;
  logic                      v4_q, v5_q, v6_q, v7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx4_q  <= ztag_o.wzero ? '0 : div_sat(qx, negx_o);
      sy4_q  <= ztag_o.wzero ? '0 : div_sat(qy, negy_o);
      qz4_q  <= div_sat(qz, ztag_o.neg);
      col4_q <= ztag_o.color;
      wz4_q  <= ztag_o.wzero;
    end
  end

  // Stage 5: offsets from the near plane
  logic signed [COORD_W:0] n5_q, d5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q   <= (COORD_W+1)'(qz4_q) - (COORD_W+1)'(near_q);
      d5_q   <= (COORD_W+1)'(far_q) - (COORD_W+1)'(near_q);
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
      col5_q <= col4_q;
      wz5_q  <= wz4_q;
    end
  end

  // Stage 6: make the range positive
  logic signed [COORD_W+1:0] n5x, d5x, n6_q;
  logic [DDW-1:0]            d6_q;
  logic                      dz6_q;
  assign n5x = (COORD_W+2)'(n5_q);
  assign d5x = (COORD_W+2)'(d5_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      n6_q   <= d5_q[COORD_W] ? -n5x : n5x;
      d6_q   <= DDW'(d5_q[COORD_W] ? -d5x : d5x);
      dz6_q  <= (d5_q == '0);
      sx6_q  <= sx5_q;
      sy6_q  <= sy5_q;
      col6_q <= col5_q;
      wz6_q  <= wz5_q;
    end
  end

  // Stage 7: clamp decision and divider setup, num*(2^32-1)/den
  vtp_side_t      side7_q, side_o;
  logic [DDW-1:0] rem7_q, den7_q;
  logic [31:0]    low7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      side7_q.sx    <= sx6_q;
      side7_q.sy    <= sy6_q;
      side7_q.color <= col6_q;
      side7_q.fault <= wz6_q || dz6_q;
      if (wz6_q || dz6_q || n6_q[COORD_W+1] || n6_q == '0) begin
        side7_q.sel <= SEL_ZERO;
      end else if (n6_q >= $signed({1'b0, d6_q})) begin
        side7_q.sel <= SEL_FULL;
      end else begin
        side7_q.sel <= SEL_QUOT;
      end
      rem7_q <= DDW'(n6_q - (COORD_W+2)'(1));
      low7_q <= 32'(-n6_q);
      den7_q <= d6_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v4_q <= vz;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Depth divider
  logic [31:0] dq;
  vtp_div #(.NW(32), .DW(DDW), .SW($bits(vtp_side_t))) u_div_depth (
    .clk_i, .rst_ni, .en_i(en), .v_i(v7_q), .rem_i(rem7_q), .num_i(low7_q),
    .den_i(den7_q), .side_i(side7_q), .v_o(v_last), .quo_o(dq), .side_o(side_o)
  );

  // Output register
  logic [31:0]  depth;
  logic [119:0] out_d_q;
  logic         fault_q;
  always_comb begin
    case (side_o.sel)
      SEL_FULL: depth = 32'hFFFF_FFFF;
      SEL_QUOT: depth = dq;
      default:  depth = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld && v_last) begin
      out_d_q <= {side_o.color, depth, side_o.sy, side_o.sx};
      fault_q <= side_o.fault;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ld) begin
      out_v_q <= v_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = fault_q;

  // Checks
  `VTP_ASSERT_IMP(a_lanes_agree, clk_i, rst_ni, 1'b1, (vx == vz) && (vy == vz),
    "divider lanes out of step")
  `VTP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready && v_last, "input stalled without a full output")
  `VTP_ASSERT_NXT(a_out_load, clk_i, rst_ni, !m_axis_tvalid && !v_last, !m_axis_tvalid,
    "result appeared from an empty last stage")

endmodule

// File: design/vtp_row_lane.sv
`timescale 1ns / 1ps
module vtp_row_lane
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] coef_i [4],
  input  logic signed [COORD_W-1:0] vec_i  [4],
  output logic signed [COORD_W-1:0] sum_o
);

  localparam int PW = 2 * COORD_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] SMAX = SW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SW-1:0] SMIN = SW'(-64'sh0000_0000_8000_0000);

  logic signed [PW-1:0] prod   [4];
  logic signed [PW-1:0] prod_q [4];
  logic signed [SW-1:0] sum;
  logic signed [COORD_W-1:0] sum_d, sum_q;

  // Full products, floored by the fraction width
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = coef_i[c] * vec_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= prod[c] >>> FRAC_BITS;
      end
    end
  end

  // Exact row sum, saturated to 32 bits
  always_comb begin
    sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
    if (sum > SMAX) begin
      sum_d = SMAX[COORD_W-1:0];
    end else if (sum < SMIN) begin
      sum_d = SMIN[COORD_W-1:0];
    end else begin
      sum_d = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: design/vtp_div.sv
`timescale 1ns / 1ps
module vtp_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] acc_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] v_q;

  // One quotient bit per stage, restoring
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] acc_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = rem_i;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign v_in    = v_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign acc_in  = acc_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    assign trial = {rem_in, acc_in[NW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        acc_q[i]  <= {acc_in[NW-2:0], ge};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end
  end

  assign v_o    = v_q[NW-1];
  assign quo_o  = acc_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule
